@@ rtl/core/c8ks_pkg.sv @@
// Shared types, constants and helper functions for the ChaCha8 keystream block.
// Used by c8ks_round_cell and chacha8_keystream_block; depends on nothing else.
`default_nettype none

package c8ks_pkg;

   // Number of ChaCha rounds. Each round is split over two half-round cells.
   localparam int ROUND_COUNT = 8;
   localparam int NUM_CELLS   = 2 * ROUND_COUNT;

   // Key register file.
   localparam int NUM_KEY_REGS    = 4;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_LOW_IDX    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_SECOND_IDX = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_THIRD_IDX  = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_HIGH_IDX   = 4'd3;

   // The four words of "expand 32-byte k".
   localparam logic [3:0][31:0] SIGMA_WORDS = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   // Rotation amounts of the first and second half of a quarter-round.
   localparam logic [4:0] ROT_FIRST_A  = 5'd16;
   localparam logic [4:0] ROT_FIRST_B  = 5'd12;
   localparam logic [4:0] ROT_SECOND_A = 5'd8;
   localparam logic [4:0] ROT_SECOND_B = 5'd7;

   typedef logic [15:0][31:0] words_type;

   typedef struct packed {
      logic [63:0] block_position;
      logic [63:0] stream_number;
   } req_type;

   typedef struct packed {
      logic [63:0] out_words_0_1;
      logic [63:0] out_words_2_3;
      logic [63:0] out_words_4_5;
      logic [63:0] out_words_6_7;
      logic [63:0] out_words_8_9;
      logic [63:0] out_words_10_11;
      logic [63:0] out_words_12_13;
      logic [63:0] out_words_14_15;
   } rsp_type;

   // Working state plus the input item, which travels along for the final add.
   typedef struct packed {
      words_type words;
      req_type   item;
   } cell_data_type;

   // Which step a cell performs: column or diagonal round, first or second half.
   typedef struct packed {
      logic diagonal;
      logic second_half;
   } step_sel_type;

   // Rotate left; always called with a constant amount between 1 and 31.
   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      return (v << n) | (v >> (32 - int'(n)));
   endfunction

   // State word index of one operand of quarter-round q. Row 0..3 selects a..d.
   // Column rounds use word 4*row+q; diagonal rounds shift each row by its number.
   function automatic logic [3:0] quarter_index(input logic diagonal,
                                                input logic [1:0] q,
                                                input logic [1:0] row);
      logic [1:0] col;
      col = diagonal ? 2'(q + row) : q;
      return {row, col};
   endfunction

   // Initial state from key and input item.
   function automatic words_type init_words(input logic [NUM_KEY_REGS-1:0][63:0] key,
                                            input req_type item);
      words_type w;
      for (int i = 0; i < 4; i++) begin
         w[i] = SIGMA_WORDS[i];
      end
      for (int i = 0; i < NUM_KEY_REGS; i++) begin
         w[4 + 2 * i] = key[i][31:0];
         w[5 + 2 * i] = key[i][63:32];
      end
      w[12] = item.block_position[31:0];
      w[13] = item.block_position[63:32];
      w[14] = item.stream_number[31:0];
      w[15] = item.stream_number[63:32];
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/chacha8_keystream_block.sv @@
// Top level of the ChaCha8 keystream generator: key registers, round chain, output stage.
// Depends on c8ks_pkg and c8ks_round_cell.
`default_nettype none

// Each accepted request (block position and stream number) yields one 512-bit
// ChaCha8 keystream block under the 256-bit key held in four 64-bit registers.
// The rounds run through a chain of sixteen half-round cells, each doing two
// add-xor-rotate steps on all four quarters, followed by a registered
// feed-forward add. One request is taken per cycle as long as responses
// are taken. Each cell holds one block, so stalls on the response side fill
// the chain before the request side sees req_ready low. Write the key only
// while no requests are in flight.
module chacha8_keystream_block (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  c8ks_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output c8ks_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write_en,
   input  logic [c8ks_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [c8ks_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int NC = c8ks_pkg::NUM_CELLS;

   logic [c8ks_pkg::NUM_KEY_REGS-1:0][63:0] key_ff;
   logic [c8ks_pkg::NUM_KEY_REGS-1:0][63:0] key_in;

   logic [NC:0]              chain_valid;
   logic [NC:0]              chain_ready;
   c8ks_pkg::cell_data_type  chain_data [NC+1];
   c8ks_pkg::step_sel_type   cell_sel [NC];

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   c8ks_pkg::rsp_type        rsp_data_ff;
   c8ks_pkg::rsp_type        rsp_data_in;
   c8ks_pkg::words_type      final_words;

   // Key register writes; an index past the last register is dropped.
   always_comb begin
      key_in = key_ff;
      if (csr_write_en) begin
         case (csr_index)
            c8ks_pkg::KEY_LOW_IDX:    key_in[0] = csr_wdata;
            c8ks_pkg::KEY_SECOND_IDX: key_in[1] = csr_wdata;
            c8ks_pkg::KEY_THIRD_IDX:  key_in[2] = csr_wdata;
            c8ks_pkg::KEY_HIGH_IDX:   key_in[3] = csr_wdata;
            default:                  key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Head of the chain: the request becomes the initial state.
   assign chain_valid[0]      = req_valid;
   assign req_ready           = chain_ready[0];
   assign chain_data[0].words = c8ks_pkg::init_words(key_ff, req_data);
   assign chain_data[0].item  = req_data;

   // Cell k does half (k odd: second half) of round k/2; odd rounds are diagonal.
   for (genvar k = 0; k < NC; k++) begin : g_cell
      assign cell_sel[k].diagonal    = 1'((k / 2) % 2);
      assign cell_sel[k].second_half = 1'(k % 2);

      c8ks_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .sel       (cell_sel[k]),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // Feed-forward add of the initial state, rebuilt from the key and the item.
   always_comb begin
      c8ks_pkg::words_type init;
      init = c8ks_pkg::init_words(key_ff, chain_data[NC].item);
      for (int i = 0; i < 16; i++) begin
         final_words[i] = chain_data[NC].words[i] + init[i];
      end
   end

   always_comb begin
      rsp_data_in.out_words_0_1   = {final_words[1],  final_words[0]};
      rsp_data_in.out_words_2_3   = {final_words[3],  final_words[2]};
      rsp_data_in.out_words_4_5   = {final_words[5],  final_words[4]};
      rsp_data_in.out_words_6_7   = {final_words[7],  final_words[6]};
      rsp_data_in.out_words_8_9   = {final_words[9],  final_words[8]};
      rsp_data_in.out_words_10_11 = {final_words[11], final_words[10]};
      rsp_data_in.out_words_12_13 = {final_words[13], final_words[12]};
      rsp_data_in.out_words_14_15 = {final_words[15], final_words[14]};
   end

   // Output register.
   assign chain_ready[NC] = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in    = chain_ready[NC] ? chain_valid[NC] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_valid[NC] && chain_ready[NC]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // With the output register empty, every cell can move, so requests are taken.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request side stalled while the output register is empty");

   // A new response only appears when the last cell held a block.
   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(chain_valid[NC]))
      else $error("response raised without a block at the end of the chain");

   // A write to the first key register lands in the next cycle.
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index == c8ks_pkg::KEY_LOW_IDX) |=> key_ff[0] == $past(csr_wdata))
      else $error("key register write lost");

   // Nothing is in flight right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && chain_valid[NC:1] == '0)
      else $error("chain not empty after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/core/c8ks_round_cell.sv @@
// One cell of the round chain: half of a ChaCha round on all four quarters.
// Depends on c8ks_pkg for the state types and the word index and rotate helpers.
`default_nettype none

module c8ks_round_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  c8ks_pkg::step_sel_type  sel,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  c8ks_pkg::cell_data_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output c8ks_pkg::cell_data_type out_data
);

   logic                    valid_ff;
   logic                    valid_in;
   c8ks_pkg::cell_data_type data_ff;
   c8ks_pkg::cell_data_type data_in;

   // The cell takes a new transfer when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Two add-xor-rotate steps of every quarter-round; the four quarters touch
   // disjoint words, so they are computed side by side.
   always_comb begin
      logic [3:0]  ia;
      logic [3:0]  ib;
      logic [3:0]  ic;
      logic [3:0]  id;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      data_in = in_data;
      for (int q = 0; q < 4; q++) begin
         ia = c8ks_pkg::quarter_index(sel.diagonal, 2'(q), 2'd0);
         ib = c8ks_pkg::quarter_index(sel.diagonal, 2'(q), 2'd1);
         ic = c8ks_pkg::quarter_index(sel.diagonal, 2'(q), 2'd2);
         id = c8ks_pkg::quarter_index(sel.diagonal, 2'(q), 2'd3);
         a = in_data.words[ia] + in_data.words[ib];
         d = in_data.words[id] ^ a;
         d = sel.second_half ? c8ks_pkg::rotl32(d, c8ks_pkg::ROT_SECOND_A)
                             : c8ks_pkg::rotl32(d, c8ks_pkg::ROT_FIRST_A);
         c = in_data.words[ic] + d;
         b = in_data.words[ib] ^ c;
         b = sel.second_half ? c8ks_pkg::rotl32(b, c8ks_pkg::ROT_SECOND_B)
                             : c8ks_pkg::rotl32(b, c8ks_pkg::ROT_FIRST_B);
         data_in.words[ia] = a;
         data_in.words[ib] = b;
         data_in.words[ic] = c;
         data_in.words[id] = d;
      end
   end

   // Occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Working state, loaded on each accepted transfer.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
